[hw/rtl/hlxr_pkg.sv]
// Shared types and constants for the header/length/XOR frame receiver.
// No dependencies; imported by hlxr_core, hlxr_out_reg, the top level and the checker.

package hlxr_pkg;

    localparam logic [7:0] HDR_FIRST      = 8'hAA;
    localparam logic [7:0] HDR_SECOND     = 8'h55;
    localparam logic [7:0] FRAME_OVERHEAD = 8'd3;
    localparam logic [7:0] CAPACITY_RESET = 8'd140;

    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_OK       = 2'd0,
        VERDICT_CSUM_ERR = 2'd1,
        VERDICT_OVERSIZE = 2'd2,
        VERDICT_REPEATED = 2'd3
    } verdict_t;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_SYNC = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_SUM  = 3'd4
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] position;
        logic [7:0] frame_length;
        logic [1:0] verdict;
    } result_t;

endpackage

[hw/rtl/hlxr_in_reg.sv]
// Input register stage: captures one received byte per transaction.
// No dependencies.

module hlxr_in_reg
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] rx_byte,
    output logic       in_stall,
    input  logic       take,
    output logic       q_valid,
    output logic [7:0] q_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    // Stage can refill whenever it is empty or its byte is consumed this cycle.
    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign q_valid = valid_reg;
    assign q_byte  = byte_reg;

endmodule

[hw/rtl/hlxr_core.sv]
// Frame parser: header hunt, length check, payload indexing, XOR check,
// failure counting and the capacity register. Depends on hlxr_pkg.

module hlxr_core
    import hlxr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic [7:0] cfg_data,
    input  logic       go,
    input  logic [7:0] b,
    output logic       res_valid,
    output result_t    res
);

    phase_t     phase_reg, phase_next;
    logic [7:0] announced_length_reg, announced_length_next;
    logic [7:0] bytes_taken_reg, bytes_taken_next;
    logic [7:0] running_xor_reg, running_xor_next;
    logic [1:0] fail_cnt_reg, fail_cnt_next;
    logic [7:0] capacity_reg;

    logic       oversize;
    logic       csum_ok;
    logic [7:0] taken_inc;

    assign oversize  = {1'b0, capacity_reg} < ({1'b0, b} + {1'b0, FRAME_OVERHEAD});
    assign csum_ok   = (b == running_xor_reg);
    assign taken_inc = bytes_taken_reg + 8'd1;

    // next state
    always_comb
    begin
        phase_next            = phase_reg;
        announced_length_next = announced_length_reg;
        bytes_taken_next      = bytes_taken_reg;
        running_xor_next      = running_xor_reg;
        fail_cnt_next         = fail_cnt_reg;
        case (phase_reg)
            PH_SYNC:
            begin
                if (b == HDR_SECOND)
                begin
                    phase_next = PH_LEN;
                end
                else if (b != HDR_FIRST)
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_LEN:
            begin
                announced_length_next = b;
                bytes_taken_next      = 8'd0;
                running_xor_next      = b;
                if (oversize)
                begin
                    phase_next = PH_HUNT;
                end
                else if (b == 8'd0)
                begin
                    phase_next = PH_SUM;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                running_xor_next = running_xor_reg ^ b;
                bytes_taken_next = taken_inc;
                if (taken_inc == announced_length_reg)
                begin
                    phase_next = PH_SUM;
                end
            end
            PH_SUM:
            begin
                phase_next = PH_HUNT;
                if (csum_ok)
                begin
                    fail_cnt_next = 2'd0;
                end
                else if (fail_cnt_reg != 2'd3)
                begin
                    fail_cnt_next = fail_cnt_reg + 2'd1;
                end
            end
            default:
            begin
                // hunting, also any unused phase code
                phase_next = (b == HDR_FIRST) ? PH_SYNC : PH_HUNT;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        res_valid        = 1'b0;
        res.kind         = KIND_PAYLOAD;
        res.data_byte    = 8'd0;
        res.position     = 8'd0;
        res.frame_length = announced_length_reg;
        res.verdict      = VERDICT_OK;
        case (phase_reg)
            PH_LEN:
            begin
                res_valid        = oversize;
                res.kind         = KIND_FRAME_END;
                res.frame_length = b;
                res.verdict      = VERDICT_OVERSIZE;
            end
            PH_DATA:
            begin
                res_valid     = 1'b1;
                res.data_byte = b;
                res.position  = bytes_taken_reg;
            end
            PH_SUM:
            begin
                res_valid = 1'b1;
                res.kind  = KIND_FRAME_END;
                if (csum_ok)
                begin
                    res.verdict = VERDICT_OK;
                end
                else if (fail_cnt_reg == 2'd3)
                begin
                    res.verdict = VERDICT_REPEATED;
                end
                else
                begin
                    res.verdict = VERDICT_CSUM_ERR;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_HUNT;
            announced_length_reg <= 8'd0;
            bytes_taken_reg      <= 8'd0;
            running_xor_reg      <= 8'd0;
            fail_cnt_reg         <= 2'd0;
            capacity_reg         <= CAPACITY_RESET;
        end
        else
        begin
            if (go)
            begin
                phase_reg            <= phase_next;
                announced_length_reg <= announced_length_next;
                bytes_taken_reg      <= bytes_taken_next;
                running_xor_reg      <= running_xor_next;
                fail_cnt_reg         <= fail_cnt_next;
            end
            if (cfg_valid)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

endmodule

[hw/rtl/hlxr_out_reg.sv]
// Result register: holds one result transaction until the receiver takes it.
// Depends on hlxr_pkg for result_t.

module hlxr_out_reg
    import hlxr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  logic    res_valid,
    input  result_t res,
    output logic    slot_free,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_q
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign slot_free  = !valid_reg || !out_stall;
    assign valid_next = load ? res_valid : (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_q     = data_reg;

endmodule

[hw/rtl/header_length_xor_frame_receiver.sv]
// Header/length/XOR-checksum frame receiver, top level.
// Input channel: in_valid/in_stall with rx_byte, one received byte per transaction.
// Output channel: out_valid/out_stall with kind, data_byte, position,
//   frame_length, verdict. Each payload byte comes out with its position;
//   the checksum byte (or an oversized length byte) yields a frame-end result.
// Config channel: cfg_valid/cfg_ready/cfg_data writes frame_capacity;
//   cfg_ready is always high. Write only while the block is idle.
// Timing: a result is shown on the output the cycle after its byte is taken
//   from the input register.
// Throughput: one byte per cycle while out_stall is low, set by the single input
//   register and the single result register around the parser.
// Header, sync, and length bytes (when not oversized) produce no result.
// Reset: parser hunts for 0xAA, counters clear, capacity returns to 140,
//   both registers empty.
// Stall: while out_stall holds a pending result, the parser halts and
//   in_stall rises once the input register is occupied.
// Depends on hlxr_pkg, hlxr_in_reg, hlxr_core, hlxr_out_reg.

module header_length_xor_frame_receiver
    import hlxr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] data_byte,
    output logic [7:0] position,
    output logic [7:0] frame_length,
    output logic [1:0] verdict,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic       q_valid;
    logic [7:0] q_byte;
    logic       slot_free;
    logic       go;
    logic       res_valid;
    result_t    res;
    result_t    out_q;

    assign go        = q_valid && slot_free;
    assign cfg_ready = 1'b1;

    hlxr_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .rx_byte  (rx_byte),
        .in_stall (in_stall),
        .take     (go),
        .q_valid  (q_valid),
        .q_byte   (q_byte)
    );

    hlxr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .go        (go),
        .b         (q_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    hlxr_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (go),
        .res_valid (res_valid),
        .res       (res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_q     (out_q)
    );

    assign kind         = out_q.kind;
    assign data_byte    = out_q.data_byte;
    assign position     = out_q.position;
    assign frame_length = out_q.frame_length;
    assign verdict      = out_q.verdict;

endmodule

[hw/rtl/hlxr_checker.sv]
// Port-level checks for the frame receiver, bound to the top level.
// Depends on hlxr_pkg and header_length_xor_frame_receiver.

module hlxr_checker
    import hlxr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       kind,
    input logic [7:0] data_byte,
    input logic [7:0] position,
    input logic [7:0] frame_length,
    input logic [1:0] verdict
);

    // a stalled result transaction stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_FRAME_END) |-> (data_byte == 8'd0) && (position == 8'd0))
        else $error("frame end carries payload fields");

    a_payload_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_PAYLOAD) |-> (verdict == VERDICT_OK))
        else $error("payload byte carries a verdict");

    a_payload_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_PAYLOAD) |-> (position < frame_length))
        else $error("payload position beyond announced length");

endmodule

bind header_length_xor_frame_receiver hlxr_checker u_hlxr_checker (.*);
